[rtl/core/jse_pkg.sv]
// ---------------------------------------------------------------------------
// JSON string escaper package
// Shared types, character codes and a helper function for the escaper.
// ---------------------------------------------------------------------------
package jse_pkg;

    // Default depth of the command queue between front and back; a power of two.
    localparam int JSE_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_OPEN  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_CLOSE = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       string_is_unicode;
        logic       new_document;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       mixed_input;
    } out_item_t;

    // How the back end expands one queued command.
    typedef enum logic [1:0] {
        OP_PLAIN = 2'd0,   // one byte, taken as it is
        OP_PAIR  = 2'd1,   // backslash, then the stored character
        OP_UNI   = 2'd2    // backslash, u, 0, 0, two hex digits
    } esc_op_t;

    typedef struct packed {
        esc_op_t    op;
        logic [7:0] ch;
        logic       mixed;
    } esc_cmd_t;

    localparam logic [2:0] PAIR_LAST_IDX = 3'd1;
    localparam logic [2:0] UNI_LAST_IDX  = 3'd5;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;

    localparam logic [7:0] CTRL_TAB = 8'h09;
    localparam logic [7:0] CTRL_LF  = 8'h0A;
    localparam logic [7:0] CTRL_CR  = 8'h0D;
    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_FF  = 8'h0C;

    localparam logic [7:0] CTRL_LIMIT  = 8'h20;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;

    // Lowercase hexadecimal digit for one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        d = {4'h0, nib};
        if (nib < 4'd10) begin
            hex_digit = CH_ZERO + d;
        end else begin
            hex_digit = 8'h57 + d;
        end
    endfunction

endpackage

[rtl/core/jse_front.sv]
// ---------------------------------------------------------------------------
// Escaper front end
// Accepts input transfers, keeps the string and document flags and turns
// each open, data or close item into one expansion command for the queue.
// ---------------------------------------------------------------------------
module jse_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic               in_ready,
    input  jse_pkg::in_item_t  in_item,
    output logic               push,
    output jse_pkg::esc_cmd_t  cmd
);
    import jse_pkg::*;

    logic cur_uni_reg, cur_uni_next;
    logic doc_uni_reg, doc_uni_next;
    logic raw_high_reg, raw_high_next;
    logic want_push;
    logic accept;

    assign accept = in_valid && in_ready;
    assign push   = accept && want_push;

    always_comb begin
        cur_uni_next  = cur_uni_reg;
        doc_uni_next  = doc_uni_reg;
        raw_high_next = raw_high_reg;
        want_push     = 1'b0;
        cmd.op        = OP_PLAIN;
        cmd.ch        = CH_QUOTE;
        case (in_item.kind)
            KIND_OPEN: begin
                // The new-document clear comes before the Unicode mark is recorded.
                if (in_item.new_document) begin
                    doc_uni_next  = 1'b0;
                    raw_high_next = 1'b0;
                end
                cur_uni_next = in_item.string_is_unicode;
                if (in_item.string_is_unicode) begin
                    doc_uni_next = 1'b1;
                end
                want_push = 1'b1;
            end
            KIND_DATA: begin
                want_push = 1'b1;
                if (in_item.data_byte < CTRL_LIMIT) begin
                    cmd.op = OP_PAIR;
                    case (in_item.data_byte)
                        CTRL_TAB: cmd.ch = CH_T;
                        CTRL_LF:  cmd.ch = CH_N;
                        CTRL_CR:  cmd.ch = CH_R;
                        CTRL_BS:  cmd.ch = CH_B;
                        CTRL_FF:  cmd.ch = CH_F;
                        default: begin
                            cmd.op = OP_UNI;
                            cmd.ch = in_item.data_byte;
                        end
                    endcase
                end else if (in_item.data_byte < ASCII_LIMIT) begin
                    cmd.ch = in_item.data_byte;
                    if (in_item.data_byte == CH_QUOTE || in_item.data_byte == CH_BSLASH) begin
                        cmd.op = OP_PAIR;
                    end
                end else begin
                    cmd.ch = in_item.data_byte;
                    if (!cur_uni_reg) begin
                        raw_high_next = 1'b1;
                    end
                end
            end
            KIND_CLOSE: begin
                want_push = 1'b1;
            end
            default: begin
                // Unused kind: no output and the flags are kept.
                want_push = 1'b0;
            end
        endcase
        cmd.mixed = doc_uni_next && raw_high_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_uni_reg  <= 1'b0;
            doc_uni_reg  <= 1'b0;
            raw_high_reg <= 1'b0;
        end else if (accept) begin
            cur_uni_reg  <= cur_uni_next;
            doc_uni_reg  <= doc_uni_next;
            raw_high_reg <= raw_high_next;
        end
    end

endmodule

[rtl/core/jse_queue.sv]
// ---------------------------------------------------------------------------
// Escaper command queue
// Small first-in first-out store of expansion commands; the depth must be a
// power of two.
// ---------------------------------------------------------------------------
module jse_queue #(
    parameter int DEPTH = jse_pkg::JSE_QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  jse_pkg::esc_cmd_t  push_cmd,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output jse_pkg::esc_cmd_t  head_cmd
);
    import jse_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    esc_cmd_t          mem [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_pop;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/jse_back.sv]
// ---------------------------------------------------------------------------
// Escaper back end
// Expands the command at the head of the queue into output bytes, one per
// cycle while the receiver takes them, through a registered output stage.
// ---------------------------------------------------------------------------
module jse_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  jse_pkg::esc_cmd_t  head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output jse_pkg::out_item_t out_item
);
    import jse_pkg::*;

    logic [2:0]  idx_reg, idx_next;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic        load;
    logic        last;
    logic [7:0]  sel_byte;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // The output stage loads when a command waits and it is empty or drained.
    assign load = head_valid && (!out_valid_reg || out_ready);
    assign pop  = load && last;

    always_comb begin
        last     = 1'b1;
        sel_byte = head_cmd.ch;
        case (head_cmd.op)
            OP_PLAIN: begin
                last     = 1'b1;
                sel_byte = head_cmd.ch;
            end
            OP_PAIR: begin
                last     = (idx_reg == PAIR_LAST_IDX);
                sel_byte = (idx_reg == 3'd0) ? CH_BSLASH : head_cmd.ch;
            end
            OP_UNI: begin
                last = (idx_reg == UNI_LAST_IDX);
                case (idx_reg)
                    3'd0:    sel_byte = CH_BSLASH;
                    3'd1:    sel_byte = CH_U;
                    3'd2:    sel_byte = CH_ZERO;
                    3'd3:    sel_byte = CH_ZERO;
                    3'd4:    sel_byte = hex_digit(head_cmd.ch[7:4]);
                    default: sel_byte = hex_digit(head_cmd.ch[3:0]);
                endcase
            end
            default: begin
                last     = 1'b1;
                sel_byte = head_cmd.ch;
            end
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_item_reg.out_byte    <= sel_byte;
            out_item_reg.last_of_run <= last;
            out_item_reg.mixed_input <= head_cmd.mixed;
        end
    end

endmodule

[rtl/core/json_string_escaper_unit.sv]
// ---------------------------------------------------------------------------
// JSON string escaper
// Turns open, data and close items into the bytes of a quoted JSON string.
// ---------------------------------------------------------------------------
// Items arrive on the s_ channel (valid/ready) and escaped bytes leave on the
// m_ channel, one byte per transfer, with last_of_run marking the final byte
// that an item produces and mixed_input carrying the document flag.
// The front end classifies each item in the cycle it is accepted and queues
// one command; the back end expands a command into 1, 2 or 6 bytes, one per
// cycle while m_ready allows, through a registered output stage.
// When the queue is empty, an accepted item is written into the queue and
// its first byte is then loaded into the registered output stage.
// Plain bytes and quotes sustain one item per cycle while the receiver keeps
// up; an escape holds the back end for each of its output bytes, so throughput
// follows the number of output bytes, with the queue absorbing short bursts.
// When the receiver stalls, the output byte holds, the queue fills and
// s_ready falls once it is full. An unused kind is taken and dropped.
// Reset clears the flags, the queue and the output stage; no clearing pass
// is needed.
// ---------------------------------------------------------------------------
module json_string_escaper_unit #(
    parameter int QUEUE_DEPTH = jse_pkg::JSE_QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  jse_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output jse_pkg::out_item_t m_payload
);
    import jse_pkg::*;

    logic      push;
    esc_cmd_t  push_cmd;
    logic      full;
    logic      pop;
    logic      head_valid;
    esc_cmd_t  head_cmd;

    assign s_ready = !full;

    jse_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_item  (s_payload),
        .push     (push),
        .cmd      (push_cmd)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    jse_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_item   (m_payload)
    );

endmodule
